/* sv/iir_filter_direct_form_one_macros.svh */
// assertion macros shared by the iir filter checker
`ifndef IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define IIRDF1_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iir filter check failed in the same cycle");

// condition holds in the cycle after the trigger
`define IIRDF1_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iir filter check failed one cycle later");

`endif

/* sv/iirdf1_pkg.sv */
// types, constants and register indexes of the direct form I iir filter
`timescale 1ns / 1ps

package iirdf1_pkg;

  // filter order, 1 to 3
  localparam int ORDER = 2;
  localparam int NUM_TERMS = 2 * ORDER + 1;
  localparam int TERM_W = $clog2(NUM_TERMS);

  // sample and coefficient formats
  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 18;
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_BIAS = 2 ** (FRAC_SHIFT - 1);
  localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

  // digit-serial multiplier
  localparam int DIGIT_W = 4;
  localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W = PROD_W + TERM_W + 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_3 = 3'd6;

  // b0 resets to 1.0 in q3.14
  localparam int B0_RESET = 2 ** FRAC_SHIFT;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_ROUND
  } state_t;

  // control from the sequencer to the multiplier
  typedef struct packed {
    logic load;
    logic step;
    logic first;
  } mac_ctrl_t;

endpackage

/* sv/iirdf1_mac.sv */
// digit-serial signed multiplier, one 4-bit digit of the sample per cycle, msb digit first
`timescale 1ns / 1ps

module iirdf1_mac (
  input  logic                 clk,
  input  iirdf1_pkg::mac_ctrl_t ctrl,
  input  iirdf1_pkg::sample_t  operand,
  input  iirdf1_pkg::coef_t    coef,
  output iirdf1_pkg::prod_t    product
);
  import iirdf1_pkg::*;

  logic [SAMPLE_W-1:0]          opnd;
  coef_t                        coef_q;
  prod_t                        prod;
  prod_t                        prod_next;
  logic signed [DIGIT_W:0]      digit;
  logic signed [COEF_W+DIGIT_W:0] part;

  // top digit carries the sign, the lower digits are unsigned
  assign digit = {ctrl.first & opnd[SAMPLE_W-1], opnd[SAMPLE_W-1 -: DIGIT_W]};
  assign part = coef_q * digit;

  // horner step: shift the partial product up one digit and add
  always_comb begin
    if (ctrl.first) begin
      prod_next = PROD_W'(part);
    end else begin
      prod_next = (prod <<< DIGIT_W) + PROD_W'(part);
    end
  end

  // operand shift register and coefficient hold
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      opnd   <= operand;
      coef_q <= coef;
    end else if (ctrl.step) begin
      opnd <= opnd << DIGIT_W;
    end
  end

  // partial product register
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      prod <= prod_next;
    end
  end

  assign product = prod;

endmodule

/* sv/iir_filter_direct_form_one.sv */
// iir_filter_direct_form_one: direct form I iir filter around one shared digit-serial mac
// an accepted item passes through ST_MAC for every tap, then ST_ACC and ST_ROUND, into the output register
// a new item is taken only back in ST_IDLE, once ST_ROUND has written the last result
// the multiplier forms one product per filter tap
// reset: b0 back to 1.0, other coefficients zero, both histories cleared, nothing in flight
`timescale 1ns / 1ps

module iir_filter_direct_form_one (
  input  logic                 clk,
  input  logic                 rst,
  // input samples
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iirdf1_pkg::sample_t  sample_in,
  // filtered samples
  output logic                 out_valid,
  input  logic                 out_stall,
  output iirdf1_pkg::sample_t  sample_out,
  output logic                 saturated,
  // coefficient writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  iirdf1_pkg::cfg_idx_t cfg_index,
  input  iirdf1_pkg::coef_t    cfg_data
);
  import iirdf1_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [TERM_W-1:0]      term;
  logic [TERM_W-1:0]      term_nxt;
  logic [DIGIT_CNT_W-1:0] digit_cnt;
  coef_t                  num_coef [0:3];
  coef_t                  den_coef [1:3];
  sample_t                input_hist [ORDER];
  sample_t                output_hist [ORDER];
  sample_t                cur_x;
  acc_t                   acc;
  acc_t                   acc_next;
  acc_t                   acc_term;
  acc_t                   rounded;
  logic                   p_sub;
  prod_t                  product;
  mac_ctrl_t              mac_ctrl;
  sample_t                mac_operand;
  coef_t                  mac_coef;
  logic                   accept;
  logic                   last_digit;
  logic                   last_term;
  logic                   write_ok;
  sample_t                y_sat;
  logic                   y_clip;

  assign cfg_ready  = 1'b1;
  assign accept     = in_valid && !in_stall;
  assign last_digit = (digit_cnt == DIGIT_CNT_W'(NUM_DIGITS - 1));
  assign last_term  = (term == TERM_W'(NUM_TERMS - 1));
  assign term_nxt   = TERM_W'(term + 1'b1);
  assign write_ok   = !out_valid || !out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    mac_ctrl      = '0;
    mac_ctrl.first = (digit_cnt == '0);
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        mac_ctrl.load = in_valid;
        if (in_valid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctrl.step = 1'b1;
        if (last_digit) begin
          if (last_term) begin
            state_next = ST_ACC;
          end else begin
            mac_ctrl.load = 1'b1;
          end
        end
      end
      ST_ACC: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (write_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // operand and coefficient for the next product
  always_comb begin
    mac_operand = sample_in;
    mac_coef    = num_coef[0];
    if (state != ST_IDLE) begin
      for (int k = 1; k <= ORDER; k++) begin
        if (term_nxt == TERM_W'(2 * k - 1)) begin
          mac_operand = input_hist[k-1];
          mac_coef    = num_coef[k];
        end
        if (term_nxt == TERM_W'(2 * k)) begin
          mac_operand = output_hist[k-1];
          mac_coef    = den_coef[k];
        end
      end
    end
  end

  iirdf1_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .operand (mac_operand),
    .coef    (mac_coef),
    .product (product)
  );

  // finished product, added for numerator taps and subtracted for denominator taps
  assign acc_term = p_sub ? -ACC_W'(product) : ACC_W'(product);

  always_comb begin
    acc_next = acc;
    if (state == ST_MAC && mac_ctrl.first && term != '0) begin
      acc_next = acc + acc_term;
    end else if (state == ST_ACC) begin
      acc_next = acc + acc_term;
    end
  end

  // round half up to q1.15 and clip
  assign rounded = (acc + ACC_W'(ROUND_BIAS)) >>> FRAC_SHIFT;

  always_comb begin
    y_clip = 1'b0;
    y_sat  = rounded[SAMPLE_W-1:0];
    if (rounded > ACC_W'(SAMPLE_MAX)) begin
      y_clip = 1'b1;
      y_sat  = SAMPLE_W'(SAMPLE_MAX);
    end else if (rounded < ACC_W'(SAMPLE_MIN)) begin
      y_clip = 1'b1;
      y_sat  = SAMPLE_W'(SAMPLE_MIN);
    end
  end

  // tap and digit counters
  always_ff @(posedge clk) begin
    if (rst) begin
      term      <= '0;
      digit_cnt <= '0;
    end else if (accept) begin
      term      <= '0;
      digit_cnt <= '0;
    end else if (state == ST_MAC) begin
      digit_cnt <= DIGIT_CNT_W'(digit_cnt + 1'b1);
      if (last_digit && !last_term) begin
        term <= term_nxt;
      end
    end
  end

  // accumulator, product sign and current sample
  always_ff @(posedge clk) begin
    if (accept) begin
      acc   <= '0;
      cur_x <= sample_in;
    end else begin
      acc <= acc_next;
    end
    if (state == ST_MAC && mac_ctrl.first) begin
      p_sub <= (term != '0) && !term[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_ROUND && write_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROUND && write_ok) begin
      sample_out <= y_sat;
      saturated  <= y_clip;
    end
  end

  // input and output histories
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER; i++) begin
        input_hist[i]  <= '0;
        output_hist[i] <= '0;
      end
    end else if (state == ST_ROUND && write_ok) begin
      for (int i = ORDER - 1; i > 0; i--) begin
        input_hist[i]  <= input_hist[i-1];
        output_hist[i] <= output_hist[i-1];
      end
      input_hist[0]  <= cur_x;
      output_hist[0] <= y_sat;
    end
  end

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_coef[0] <= COEF_W'(B0_RESET);
      num_coef[1] <= '0;
      num_coef[2] <= '0;
      num_coef[3] <= '0;
      den_coef[1] <= '0;
      den_coef[2] <= '0;
      den_coef[3] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_COEF_0: num_coef[0] <= cfg_data;
        REG_NUM_COEF_1: num_coef[1] <= cfg_data;
        REG_NUM_COEF_2: num_coef[2] <= cfg_data;
        REG_NUM_COEF_3: num_coef[3] <= cfg_data;
        REG_DEN_COEF_1: den_coef[1] <= cfg_data;
        REG_DEN_COEF_2: den_coef[2] <= cfg_data;
        REG_DEN_COEF_3: den_coef[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/iirdf1_checker.sv */
// port-level checks for the iir filter and their binding to the top level
`timescale 1ns / 1ps
`include "iir_filter_direct_form_one_macros.svh"

module iirdf1_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input iirdf1_pkg::sample_t sample_out,
  input logic                saturated
);
  import iirdf1_pkg::*;

  // a stalled result stays offered
  `IIRDF1_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // a stalled result keeps its value
  `IIRDF1_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(sample_out) && $stable(saturated))

  // a clipped result sits at one of the two rails
  `IIRDF1_ASSERT_NOW(a_sat_rail, clk, rst, out_valid && saturated, sample_out == SAMPLE_W'(SAMPLE_MAX) || sample_out == SAMPLE_W'(SAMPLE_MIN))

  // one item at a time: the input stalls right after an item is taken
  `IIRDF1_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall)

  // no result can appear the cycle after an item is taken
  `IIRDF1_ASSERT_NEXT(a_no_instant_out, clk, rst, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind iir_filter_direct_form_one iirdf1_checker u_checker (.*);

/* tb/tb.sv */
// self-checking testbench of the direct form i iir filter
`timescale 1ns / 1ps

module tb;
  import iirdf1_pkg::*;

  // effective filter order and run limits
  localparam int TAPS = (ORDER < 1) ? 1 : ((ORDER > 3) ? 3 : ORDER);
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS = 1500;
  localparam int TAIL_ITEMS = 150;
  localparam cfg_idx_t CFG_NO_REG = 3'd7;
  localparam coef_t COEF_HI = 18'sh1ffff;
  localparam coef_t COEF_LO = 18'sh20000;

  typedef struct {
    sample_t sample;
    logic    clipped;
  } filtered_t;

  typedef enum int {
    COEF_FULL,
    COEF_MILD,
    COEF_EDGE
  } coef_style_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t sample_in = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t sample_out;
  logic    saturated;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  cfg_idx_t cfg_index = '0;
  coef_t   cfg_data = '0;

  // filter state as the block should hold it
  coef_t   b_coef [0:3];
  coef_t   a_coef [1:3];
  sample_t x_hist [0:2];
  sample_t y_hist [0:2];

  sample_t   samples_to_send [$];
  filtered_t filtered_due [$];

  int  mismatches = 0;
  int  taken_count = 0;
  int  seen_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  send_gap_pct = 0;
  int  stall_pct = 0;
  bit  quiet_tail = 1'b0;
  bit  hold_request = 1'b0;
  bit  hold_served = 1'b0;
  int  hold_count = 0;

  iir_filter_direct_form_one i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // one filter step: exact sum, round half up, saturate, shift histories
  function automatic filtered_t filter_step(sample_t x);
    longint    acc;
    longint    rounded;
    filtered_t res;
    acc = longint'(x) * longint'(b_coef[0]);
    for (int k = 1; k <= TAPS; k++) begin
      acc += longint'(x_hist[k-1]) * longint'(b_coef[k]);
      acc -= longint'(y_hist[k-1]) * longint'(a_coef[k]);
    end
    rounded = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
    res.clipped = 1'b0;
    if (rounded > SAMPLE_MAX) begin
      rounded = SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (rounded < SAMPLE_MIN) begin
      rounded = SAMPLE_MIN;
      res.clipped = 1'b1;
    end
    res.sample = sample_t'(rounded);
    for (int k = TAPS - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = res.sample;
    return res;
  endfunction

  // prediction on accepted items, coefficient tracking, result checking
  always @(posedge clk) begin
    filtered_t got_due;
    if (rst) begin
      b_coef[0] = coef_t'(B0_RESET);
      for (int k = 1; k <= 3; k++) begin
        b_coef[k] = '0;
        a_coef[k] = '0;
      end
      for (int k = 0; k < 3; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        filtered_due.push_back(filter_step(sample_in));
        taken_count++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_COEF_0: b_coef[0] = cfg_data;
          REG_NUM_COEF_1: b_coef[1] = cfg_data;
          REG_NUM_COEF_2: b_coef[2] = cfg_data;
          REG_NUM_COEF_3: b_coef[3] = cfg_data;
          REG_DEN_COEF_1: a_coef[1] = cfg_data;
          REG_DEN_COEF_2: a_coef[2] = cfg_data;
          REG_DEN_COEF_3: a_coef[3] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (filtered_due.size() == 0) begin
          $error("unexpected item: sample_out %0d saturated %0b", sample_out, saturated);
          mismatches++;
        end else begin
          got_due = filtered_due.pop_front();
          if (sample_out !== got_due.sample) begin
            $error("sample_out: expected %0d, actual %0d", got_due.sample, sample_out);
            mismatches++;
          end
          if (saturated !== got_due.clipped) begin
            $error("saturated: expected %0b, actual %0b", got_due.clipped, saturated);
            mismatches++;
          end
        end
      end
    end
  end

  // sender: next item or a gap once the current item is taken
  always @(negedge clk) begin
    bit taken;
    taken = (taken_count != seen_count);
    seen_count = taken_count;
    if (!rst && (!in_valid || taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (samples_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < send_gap_pct) begin
        send_gap = $urandom_range(1, 15) - 1;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        sample_in <= samples_to_send.pop_front();
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_request && !hold_served) begin
      if (hold_count >= HOLD_CYCLES) hold_served = 1'b1;
      else hold_count++;
    end
  end

  // receiver: random stall bursts plus the long hold-off
  always @(negedge clk) begin
    bit burst;
    burst = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      burst = 1'b1;
    end else if (!rst && !quiet_tail && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 15) - 1;
      burst = 1'b1;
    end
    out_stall <= burst || (hold_request && !hold_served);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_coef(cfg_idx_t idx, coef_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_filter(coef_t b0, coef_t b1, coef_t b2, coef_t b3,
                                coef_t a1, coef_t a2, coef_t a3);
    write_coef(REG_NUM_COEF_0, b0);
    write_coef(REG_NUM_COEF_1, b1);
    write_coef(REG_NUM_COEF_2, b2);
    write_coef(REG_NUM_COEF_3, b3);
    write_coef(REG_DEN_COEF_1, a1);
    write_coef(REG_DEN_COEF_2, a2);
    write_coef(REG_DEN_COEF_3, a3);
  endtask

  // wait until every item has gone through and the block is idle
  task automatic drain();
    while (samples_to_send.size() != 0 || in_valid || filtered_due.size() != 0)
      @(posedge clk);
  endtask

  function automatic coef_t rand_coef(coef_style_t style);
    case (style)
      COEF_FULL: return coef_t'($urandom);
      COEF_MILD: return coef_t'(int'($urandom_range(0, 16384)) - 8192);
      default: begin
        case ($urandom_range(0, 4))
          0: return COEF_HI;
          1: return COEF_LO;
          2: return coef_t'(B0_RESET);
          3: return coef_t'(-B0_RESET);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
      1, 2: return sample_t'(int'($urandom_range(0, 1023)) - 512);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  // one random setting of the coefficients followed by a block of items
  task automatic random_phase(int n);
    coef_style_t style;
    style = coef_style_t'($urandom_range(0, 2));
    program_filter(rand_coef(style), rand_coef(style), rand_coef(style), rand_coef(style),
                   rand_coef(style), rand_coef(style), rand_coef(style));
    if ($urandom_range(0, 3) == 0) write_coef(CFG_NO_REG, coef_t'($urandom));
    send_gap_pct = pick_idle_pct();
    stall_pct = pick_idle_pct();
    repeat (n) samples_to_send.push_back(rand_sample());
    drain();
  endtask

  // stimulus sequence
  initial begin
    int random_sent;
    random_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coefficients pass samples straight through
    send_gap_pct = 20;
    stall_pct = 20;
    samples_to_send = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff,
                        16'sh5555, 16'shaaaa, 16'sh4000};
    drain();

    // largest coefficients everywhere, deep saturation with clipped feedback
    program_filter(COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI, COEF_HI);
    samples_to_send = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001};
    drain();

    // most negative coefficients everywhere
    program_filter(COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO, COEF_LO);
    samples_to_send = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    drain();

    // smallest gain, rounding at and around the half step, stray index ignored
    program_filter(18'sd1, '0, '0, '0, '0, '0, '0);
    write_coef(CFG_NO_REG, COEF_HI);
    samples_to_send = '{16'sh2000, 16'she000, 16'shdfff, 16'sh1fff, 16'sh6000};
    drain();

    // receiver holds off for a long stretch while items keep coming
    hold_request = 1'b1;
    random_phase(60);
    random_sent += 60;

    while (random_sent < RANDOM_ITEMS) begin
      int n;
      n = $urandom_range(20, 80);
      random_phase(n);
      random_sent += n;
    end

    // last part with no idling on either side
    quiet_tail = 1'b1;
    random_phase(TAIL_ITEMS);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && filtered_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/iirdf1_pkg.sv
sv/iirdf1_mac.sv
sv/iir_filter_direct_form_one.sv
sv/iirdf1_checker.sv
tb/tb.sv
